// File: hdl/vdpm_pkg.sv
// Package: shared constants, register codes, types and helpers of the viewport pixel mapper.
`default_nettype none
package vdpm_pkg;

   // Default values of the top level parameters
   localparam int STATUSBAR_H_DEF = 32;
   localparam int TILE_W_DEF      = 256;
   localparam int TILE_H_DEF      = 256;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register map, one 32-bit word per register
   typedef enum logic [2:0] {
      CSR_VIEW_LEFT      = 3'd0,
      CSR_VIEW_TOP       = 3'd1,
      CSR_ZOOM_MODE      = 3'd2,
      CSR_FIT_DECIMATION = 3'd3,
      CSR_PANEL_WIDTH    = 3'd4,
      CSR_PANEL_HEIGHT   = 3'd5,
      CSR_PAGE_WIDTH     = 3'd6,
      CSR_PAGE_HEIGHT    = 3'd7
   } csr_index_type;

   // Register reset values
   localparam logic [15:0] VIEW_LEFT_RST      = 16'd0;
   localparam logic [15:0] VIEW_TOP_RST       = 16'd0;
   localparam logic        ZOOM_MODE_RST      = 1'b0;
   localparam logic [7:0]  FIT_DECIMATION_RST = 8'd1;
   localparam logic [11:0] PANEL_WIDTH_RST    = 12'd800;
   localparam logic [11:0] PANEL_HEIGHT_RST   = 12'd480;
   localparam logic [15:0] PAGE_WIDTH_RST     = 16'd1;
   localparam logic [15:0] PAGE_HEIGHT_RST    = 16'd1;

   // Zoom mode codes
   localparam logic ZOOM_ONE_TO_ONE = 1'b0;
   localparam logic ZOOM_FIT        = 1'b1;

   // Divider pipeline: numerators never exceed 17 bits, the decimation is 8 bits
   localparam int DIV_NUM_W = 17;
   localparam int DIV_DEN_W = 8;
   localparam int DIV_LANES = 4;

   // Divider lanes
   localparam int LANE_NX = 0;   // ceiling-biased region width
   localparam int LANE_NY = 1;   // ceiling-biased region height
   localparam int LANE_RX = 2;   // column offset inside the region
   localparam int LANE_RY = 3;   // row offset inside the region

   // Word fields that ride alongside the divider
   typedef struct packed {
      logic       keep;
      logic [7:0] gray;
   } div_side_type;

   // Gray replicated into the three RGB565 fields
   function automatic logic [15:0] pack_rgb565(input logic [7:0] gray);
      pack_rgb565 = {gray[7:3], gray[7:2], gray[7:3]};
   endfunction

endpackage
`default_nettype wire

// File: hdl/vdpm_req_if.sv
// Interface: input pixel channel of the viewport pixel mapper.
`default_nettype none
interface vdpm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] tile_col_index;
   logic [7:0] tile_row_index;
   logic [7:0] pixel_col;
   logic [7:0] pixel_row;
   logic [7:0] gray;

   modport source (
      output valid, tile_col_index, tile_row_index, pixel_col, pixel_row, gray,
      input  ready
   );
   modport sink (
      input  valid, tile_col_index, tile_row_index, pixel_col, pixel_row, gray,
      output ready
   );
endinterface
`default_nettype wire

// File: hdl/vdpm_rsp_if.sv
// Interface: mapped panel pixel channel of the viewport pixel mapper.
`default_nettype none
interface vdpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] panel_x;
   logic [11:0] panel_y;
   logic [23:0] panel_addr;
   logic [15:0] rgb565;

   modport source (
      output valid, panel_x, panel_y, panel_addr, rgb565,
      input  ready
   );
   modport sink (
      input  valid, panel_x, panel_y, panel_addr, rgb565,
      output ready
   );
endinterface
`default_nettype wire

// File: hdl/vdpm_div_pipe.sv
// Module: multi-lane restoring divider pipeline, one quotient bit per stage.
`default_nettype none
module vdpm_div_pipe #(
   parameter int NUM_W = vdpm_pkg::DIV_NUM_W,
   parameter int DEN_W = vdpm_pkg::DIV_DEN_W,
   parameter int LANES = vdpm_pkg::DIV_LANES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [NUM_W-1:0]       in_num [LANES],
   input  logic [DEN_W-1:0]       in_den,
   input  vdpm_pkg::div_side_type in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [NUM_W-1:0]       out_quo [LANES],
   output logic [DEN_W-1:0]       out_rem [LANES],
   output vdpm_pkg::div_side_type out_side
);

   // Each stage holds the partial remainder and a word that shifts the
   // remaining numerator bits out at the top and quotient bits in at the bottom.
   logic [NUM_W-1:0]       valid_ff;
   logic [NUM_W-1:0]       valid_in;
   logic [DEN_W-1:0]       den_ff  [NUM_W];
   logic [DEN_W-1:0]       den_in  [NUM_W];
   vdpm_pkg::div_side_type side_ff [NUM_W];
   vdpm_pkg::div_side_type side_in [NUM_W];
   logic [DEN_W-1:0]       rem_ff  [NUM_W][LANES];
   logic [DEN_W-1:0]       rem_in  [NUM_W][LANES];
   logic [NUM_W-1:0]       nq_ff   [NUM_W][LANES];
   logic [NUM_W-1:0]       nq_in   [NUM_W][LANES];
   logic                   advance;

   // The whole divider moves as one; it holds only when its last stage waits.
   assign advance  = out_ready || !valid_ff[NUM_W-1];
   assign in_ready = advance;

   always_comb begin : step_logic
      logic [DEN_W-1:0] src_rem;
      logic [NUM_W-1:0] src_nq;
      logic [DEN_W-1:0] src_den;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             fits;
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            valid_in[k] = in_valid;
            den_in[k]   = in_den;
            side_in[k]  = in_side;
         end else begin
            valid_in[k] = valid_ff[k-1];
            den_in[k]   = den_ff[k-1];
            side_in[k]  = side_ff[k-1];
         end
         src_den = den_in[k];
         for (int l = 0; l < LANES; l++) begin
            if (k == 0) begin
               src_rem = '0;
               src_nq  = in_num[l];
            end else begin
               src_rem = rem_ff[k-1][l];
               src_nq  = nq_ff[k-1][l];
            end
            trial = {src_rem, src_nq[NUM_W-1]};
            fits  = trial >= {1'b0, src_den};
            diff  = trial - {1'b0, src_den};
            rem_in[k][l] = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_in[k][l]  = {src_nq[NUM_W-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NUM_W; k++) begin
            if (valid_in[k]) begin
               den_ff[k]  <= den_in[k];
               side_ff[k] <= side_in[k];
               for (int l = 0; l < LANES; l++) begin
                  rem_ff[k][l] <= rem_in[k][l];
                  nq_ff[k][l]  <= nq_in[k][l];
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = nq_ff[NUM_W-1][l];
         out_rem[l] = rem_ff[NUM_W-1][l];
      end
   end

endmodule
`default_nettype wire

// File: hdl/viewport_decimating_pixel_mapper.sv
// Top level: maps gray8 page pixels onto a decimated, centred RGB565 panel viewport.
//
// Usage. Page pixels arrive as words on req_bus (tile column and row index,
// position inside the tile, gray value) and are accepted when valid and ready
// are both high. Each word yields at most one word on rsp_bus: the panel
// column and row, the linear framebuffer address and the RGB565 colour.
// Pixels outside the viewport, off the decimation grid or off the panel
// produce no word at all, and the order of the surviving words is kept.
// A word passes two front stages, a 17-stage restoring divider (one quotient
// bit per stage, four lanes) and two back stages feeding the output register.
// While rsp_bus does not stall, a new word can be taken on every cycle, so
// the sustained rate is one word per cycle. When the receiver stalls, the
// output register holds its word and the stages outside the divider fill
// their empty slots before ready drops; the divider moves as one and holds
// while its last stage waits, so nothing is lost or repeated. The view and
// panel registers are written over the csr_ APB port, one 32-bit word per
// register at byte address 4*index; they are expected to change only while
// no word is in flight. Synchronous reset empties the pipeline and restores
// the register defaults (800 by 480 panel, one-to-one zoom, a one-pixel page).
`default_nettype none
module viewport_decimating_pixel_mapper #(
   parameter int STATUSBAR_H = vdpm_pkg::STATUSBAR_H_DEF,
   parameter int TILE_W      = vdpm_pkg::TILE_W_DEF,
   parameter int TILE_H      = vdpm_pkg::TILE_H_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   vdpm_req_if.sink                        req_bus,
   vdpm_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vdpm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vdpm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vdpm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   // Page coordinates of a pixel: tile index times tile size plus offset.
   localparam int SX_W  = $clog2(256 * TILE_W);
   localparam int SY_W  = $clog2(256 * TILE_H);
   // Common width for the region compares (signed for rows) and differences.
   localparam int CMP_W = 24;
   // Width of the unclamped panel position sums.
   localparam int POS_W = 18;
   localparam int NUM_W = vdpm_pkg::DIV_NUM_W;
   localparam int DEN_W = vdpm_pkg::DIV_DEN_W;
   localparam int LANES = vdpm_pkg::DIV_LANES;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0] view_left_ff;
   logic [15:0] view_top_ff;
   logic        zoom_mode_ff;
   logic [7:0]  fit_decimation_ff;
   logic [11:0] panel_width_ff;
   logic [11:0] panel_height_ff;
   logic [15:0] page_width_ff;
   logic [15:0] page_height_ff;

   logic                    csr_write;
   vdpm_pkg::csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = vdpm_pkg::csr_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         view_left_ff      <= vdpm_pkg::VIEW_LEFT_RST;
         view_top_ff       <= vdpm_pkg::VIEW_TOP_RST;
         zoom_mode_ff      <= vdpm_pkg::ZOOM_MODE_RST;
         fit_decimation_ff <= vdpm_pkg::FIT_DECIMATION_RST;
         panel_width_ff    <= vdpm_pkg::PANEL_WIDTH_RST;
         panel_height_ff   <= vdpm_pkg::PANEL_HEIGHT_RST;
         page_width_ff     <= vdpm_pkg::PAGE_WIDTH_RST;
         page_height_ff    <= vdpm_pkg::PAGE_HEIGHT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            vdpm_pkg::CSR_VIEW_LEFT:      view_left_ff      <= csr_pwdata[15:0];
            vdpm_pkg::CSR_VIEW_TOP:       view_top_ff       <= csr_pwdata[15:0];
            vdpm_pkg::CSR_ZOOM_MODE:      zoom_mode_ff      <= csr_pwdata[0];
            vdpm_pkg::CSR_FIT_DECIMATION: fit_decimation_ff <= csr_pwdata[7:0];
            vdpm_pkg::CSR_PANEL_WIDTH:    panel_width_ff    <= csr_pwdata[11:0];
            vdpm_pkg::CSR_PANEL_HEIGHT:   panel_height_ff   <= csr_pwdata[11:0];
            vdpm_pkg::CSR_PAGE_WIDTH:     page_width_ff     <= csr_pwdata[15:0];
            vdpm_pkg::CSR_PAGE_HEIGHT:    page_height_ff    <= csr_pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         vdpm_pkg::CSR_VIEW_LEFT:      csr_prdata = 32'(view_left_ff);
         vdpm_pkg::CSR_VIEW_TOP:       csr_prdata = 32'(view_top_ff);
         vdpm_pkg::CSR_ZOOM_MODE:      csr_prdata = 32'(zoom_mode_ff);
         vdpm_pkg::CSR_FIT_DECIMATION: csr_prdata = 32'(fit_decimation_ff);
         vdpm_pkg::CSR_PANEL_WIDTH:    csr_prdata = 32'(panel_width_ff);
         vdpm_pkg::CSR_PANEL_HEIGHT:   csr_prdata = 32'(panel_height_ff);
         vdpm_pkg::CSR_PAGE_WIDTH:     csr_prdata = 32'(page_width_ff);
         vdpm_pkg::CSR_PAGE_HEIGHT:    csr_prdata = 32'(page_height_ff);
      endcase
   end

   // ------------------------------------------------------------------
   // Values that follow from the registers alone
   // ------------------------------------------------------------------
   logic [7:0]         scale;     // decimation step; a zero factor acts as one
   logic signed [13:0] ch_sg;     // content height below the status bar, may be negative
   logic [11:0]        ch_rows;   // the same, only meaningful when positive

   assign scale = ((zoom_mode_ff == vdpm_pkg::ZOOM_FIT) && (fit_decimation_ff != 8'd0)) ?
                  fit_decimation_ff : 8'd1;
   assign ch_sg   = $signed({2'b00, panel_height_ff}) - $signed(14'(STATUSBAR_H));
   assign ch_rows = panel_height_ff - 12'(STATUSBAR_H);

   // ------------------------------------------------------------------
   // Handshake chain. Each stage frees itself when empty or when the stage
   // ahead takes its word; a dropped pixel frees the last stage at once.
   // ------------------------------------------------------------------
   logic st1_valid_ff, st2_valid_ff, st3_valid_ff, st4_valid_ff, rsp_valid_ff;
   logic st4_keep_ff;
   logic st1_take, st2_take, st3_take, st4_take, out_take;
   logic div_in_ready, div_out_valid;

   assign out_take = !rsp_valid_ff || rsp_bus.ready;
   assign st4_take = !st4_valid_ff || !st4_keep_ff || out_take;
   assign st3_take = !st3_valid_ff || st4_take;
   assign st2_take = !st2_valid_ff || div_in_ready;
   assign st1_take = !st1_valid_ff || st2_take;

   assign req_bus.ready = st1_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (st1_take) begin
            st1_valid_ff <= req_bus.valid;
         end
         if (st2_take) begin
            st2_valid_ff <= st1_valid_ff;
         end
         if (st3_take) begin
            st3_valid_ff <= div_out_valid;
         end
         if (st4_take) begin
            st4_valid_ff <= st3_valid_ff;
         end
         if (out_take) begin
            rsp_valid_ff <= st4_valid_ff && st4_keep_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: page coordinates and the region extent products
   // ------------------------------------------------------------------
   logic               st1_keep_ff,  st1_keep_in;
   logic [7:0]         st1_gray_ff;
   logic [SX_W-1:0]    st1_sx_ff,    st1_sx_in;
   logic [SY_W-1:0]    st1_sy_ff,    st1_sy_in;
   logic [19:0]        st1_xprod_ff, st1_xprod_in;
   logic signed [22:0] st1_yprod_ff, st1_yprod_in;

   assign st1_sx_in = SX_W'(req_bus.tile_col_index) * SX_W'(TILE_W) + SX_W'(req_bus.pixel_col);
   assign st1_sy_in = SY_W'(req_bus.tile_row_index) * SY_W'(TILE_H) + SY_W'(req_bus.pixel_row);
   // A position past the tile edge can only arise for tile sizes below 256.
   assign st1_keep_in  = (32'(req_bus.pixel_col) < TILE_W) && (32'(req_bus.pixel_row) < TILE_H);
   assign st1_xprod_in = 20'(panel_width_ff) * 20'(scale);
   assign st1_yprod_in = 23'(ch_sg) * 23'($signed({1'b0, scale}));

   always_ff @(posedge clock) begin
      if (st1_take && req_bus.valid) begin
         st1_keep_ff  <= st1_keep_in;
         st1_gray_ff  <= req_bus.gray;
         st1_sx_ff    <= st1_sx_in;
         st1_sy_ff    <= st1_sy_in;
         st1_xprod_ff <= st1_xprod_in;
         st1_yprod_ff <= st1_yprod_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: region end clamped to the page
   // ------------------------------------------------------------------
   logic                    st2_keep_ff;
   logic [7:0]              st2_gray_ff;
   logic [SX_W-1:0]         st2_sx_ff;
   logic [SY_W-1:0]         st2_sy_ff;
   logic [15:0]             st2_x1_ff, st2_x1_in;
   logic signed [CMP_W-1:0] st2_y1_ff, st2_y1_in;
   logic [20:0]             x_end;
   logic signed [CMP_W-1:0] y_end;
   logic signed [CMP_W-1:0] page_h_sg;

   assign x_end     = 21'(view_left_ff) + 21'(st1_xprod_ff);
   assign st2_x1_in = (x_end > 21'(page_width_ff)) ? page_width_ff : x_end[15:0];
   assign page_h_sg = $signed(CMP_W'(page_height_ff));
   assign y_end     = $signed(CMP_W'(view_top_ff)) + CMP_W'(st1_yprod_ff);
   assign st2_y1_in = (y_end > page_h_sg) ? page_h_sg : y_end;

   always_ff @(posedge clock) begin
      if (st2_take && st1_valid_ff) begin
         st2_keep_ff <= st1_keep_ff;
         st2_gray_ff <= st1_gray_ff;
         st2_sx_ff   <= st1_sx_ff;
         st2_sy_ff   <= st1_sy_ff;
         st2_x1_ff   <= st2_x1_in;
         st2_y1_ff   <= st2_y1_in;
      end
   end

   // ------------------------------------------------------------------
   // Region test and divider operands. Inside the region the offsets and
   // extents stay below 2^16, so 17-bit numerators are always enough.
   // ------------------------------------------------------------------
   logic                   in_x, in_y;
   logic [CMP_W-1:0]       sx_ext, sy_ext;
   logic [CMP_W-1:0]       nx_w, ny_w, rx_w, ry_w;
   logic [NUM_W-1:0]       div_num [LANES];
   vdpm_pkg::div_side_type div_in_side;

   assign sx_ext = CMP_W'(st2_sx_ff);
   assign sy_ext = CMP_W'(st2_sy_ff);
   assign in_x   = (sx_ext >= CMP_W'(view_left_ff)) && (sx_ext < CMP_W'(st2_x1_ff));
   assign in_y   = ($signed(sy_ext) >= $signed(CMP_W'(view_top_ff))) &&
                   ($signed(sy_ext) < st2_y1_ff);

   // Ceiling division is done as a floor division of extent plus step minus one.
   assign nx_w = CMP_W'(st2_x1_ff) - CMP_W'(view_left_ff) + CMP_W'(scale) - CMP_W'(1);
   assign ny_w = $unsigned(st2_y1_ff) - CMP_W'(view_top_ff) + CMP_W'(scale) - CMP_W'(1);
   assign rx_w = sx_ext - CMP_W'(view_left_ff);
   assign ry_w = sy_ext - CMP_W'(view_top_ff);

   always_comb begin
      div_num[vdpm_pkg::LANE_NX] = nx_w[NUM_W-1:0];
      div_num[vdpm_pkg::LANE_NY] = ny_w[NUM_W-1:0];
      div_num[vdpm_pkg::LANE_RX] = rx_w[NUM_W-1:0];
      div_num[vdpm_pkg::LANE_RY] = ry_w[NUM_W-1:0];
   end

   assign div_in_side.keep = st2_keep_ff && in_x && in_y;
   assign div_in_side.gray = st2_gray_ff;

   logic [NUM_W-1:0]       div_quo [LANES];
   logic [DEN_W-1:0]       div_rem [LANES];
   vdpm_pkg::div_side_type div_out_side;

   vdpm_div_pipe #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .LANES (LANES)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st2_valid_ff),
      .in_ready  (div_in_ready),
      .in_num    (div_num),
      .in_den    (scale),
      .in_side   (div_in_side),
      .out_valid (div_out_valid),
      .out_ready (st3_take),
      .out_quo   (div_quo),
      .out_rem   (div_rem),
      .out_side  (div_out_side)
   );

   // ------------------------------------------------------------------
   // Stage 3: centring offsets and the decimation grid test. The displayed
   // size never exceeds the panel, so the offsets are never negative.
   // ------------------------------------------------------------------
   logic             st3_keep_ff, st3_keep_in;
   logic [7:0]       st3_gray_ff;
   logic [11:0]      st3_ox_ff, st3_ox_in;
   logic [11:0]      st3_oy_ff, st3_oy_in;
   logic [NUM_W-1:0] st3_qrx_ff, st3_qry_ff;
   logic [11:0]      wdiff, hdiff;

   assign wdiff       = panel_width_ff - div_quo[vdpm_pkg::LANE_NX][11:0];
   assign hdiff       = ch_rows - div_quo[vdpm_pkg::LANE_NY][11:0];
   assign st3_ox_in   = {1'b0, wdiff[11:1]};
   assign st3_oy_in   = {1'b0, hdiff[11:1]};
   assign st3_keep_in = div_out_side.keep &&
                        (div_rem[vdpm_pkg::LANE_RX] == '0) &&
                        (div_rem[vdpm_pkg::LANE_RY] == '0);

   always_ff @(posedge clock) begin
      if (st3_take && div_out_valid) begin
         st3_keep_ff <= st3_keep_in;
         st3_gray_ff <= div_out_side.gray;
         st3_ox_ff   <= st3_ox_in;
         st3_oy_ff   <= st3_oy_in;
         st3_qrx_ff  <= div_quo[vdpm_pkg::LANE_RX];
         st3_qry_ff  <= div_quo[vdpm_pkg::LANE_RY];
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: panel position and the panel bounds test
   // ------------------------------------------------------------------
   logic             st4_keep_in;
   logic [7:0]       st4_gray_ff;
   logic [11:0]      st4_px_ff, st4_py_ff;
   logic [POS_W-1:0] px_w, py_w;

   assign px_w = POS_W'(st3_ox_ff) + POS_W'(st3_qrx_ff);
   assign py_w = POS_W'(STATUSBAR_H) + POS_W'(st3_oy_ff) + POS_W'(st3_qry_ff);
   assign st4_keep_in = st3_keep_ff &&
                        (px_w < POS_W'(panel_width_ff)) &&
                        (py_w < POS_W'(panel_height_ff)) &&
                        (py_w >= POS_W'(STATUSBAR_H));

   always_ff @(posedge clock) begin
      if (st4_take && st3_valid_ff) begin
         st4_keep_ff <= st4_keep_in;
         st4_gray_ff <= st3_gray_ff;
         st4_px_ff   <= px_w[11:0];
         st4_py_ff   <= py_w[11:0];
      end
   end

   // ------------------------------------------------------------------
   // Output register: framebuffer address and colour
   // ------------------------------------------------------------------
   logic [11:0] rsp_px_ff, rsp_py_ff;
   logic [23:0] rsp_addr_ff, rsp_addr_in;
   logic [15:0] rsp_rgb_ff;

   assign rsp_addr_in = 24'(st4_py_ff) * 24'(panel_width_ff) + 24'(st4_px_ff);

   always_ff @(posedge clock) begin
      if (out_take && st4_valid_ff && st4_keep_ff) begin
         rsp_px_ff   <= st4_px_ff;
         rsp_py_ff   <= st4_py_ff;
         rsp_addr_ff <= rsp_addr_in;
         rsp_rgb_ff  <= vdpm_pkg::pack_rgb565(st4_gray_ff);
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.panel_x    = rsp_px_ff;
   assign rsp_bus.panel_y    = rsp_py_ff;
   assign rsp_bus.panel_addr = rsp_addr_ff;
   assign rsp_bus.rgb565     = rsp_rgb_ff;

endmodule
`default_nettype wire

// File: hdl/vdpm_checker.sv
// Checker: port-level assertions for the viewport pixel mapper, bound to the top level.
`default_nettype none
module vdpm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [11:0]                     rsp_panel_x,
   input logic [11:0]                     rsp_panel_y,
   input logic [23:0]                     rsp_panel_addr,
   input logic [15:0]                     rsp_rgb565,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic                            csr_pready,
   input logic [vdpm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [vdpm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [vdpm_pkg::CSR_DATA_W-1:0] csr_prdata
);

   logic        req_take, rsp_take, csr_write;
   logic [31:0] pending_ff;

   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Words taken in but not yet matched by a delivered word. Dropped pixels
   // are never matched, so the count can grow without bound over a run and must be wide.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 32'(req_take) - 32'(rsp_take);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_panel_x) &&
      $stable(rsp_panel_y) && $stable(rsp_panel_addr) && $stable(rsp_rgb565))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present straight after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> pending_ff != 32'd0)
      else $error("result word delivered without a matching input word");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write &&
      (vdpm_pkg::csr_index_type'(csr_paddr[4:2]) == vdpm_pkg::CSR_VIEW_LEFT) |=>
      (vdpm_pkg::csr_index_type'(csr_paddr[4:2]) != vdpm_pkg::CSR_VIEW_LEFT) ||
      (csr_prdata == {16'h0000, $past(csr_pwdata[15:0])}))
      else $error("view left register does not read back its written value");

endmodule

bind viewport_decimating_pixel_mapper vdpm_checker u_vdpm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_panel_x    (rsp_bus.panel_x),
   .rsp_panel_y    (rsp_bus.panel_y),
   .rsp_panel_addr (rsp_bus.panel_addr),
   .rsp_rgb565     (rsp_bus.rgb565),
   .csr_psel       (csr_psel),
   .csr_penable    (csr_penable),
   .csr_pwrite     (csr_pwrite),
   .csr_pready     (csr_pready),
   .csr_paddr      (csr_paddr),
   .csr_pwdata     (csr_pwdata),
   .csr_prdata     (csr_prdata)
);
`default_nettype wire
